// File: rtl/core/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and character constants for the short filename converter.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 4;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_LA    = 8'h61;
    localparam t_char CH_LZ    = 8'h7A;
    localparam t_char CASE_OFS = 8'h20;

    // Extension used when the name carries no dot: "COM".
    localparam int    DEF_EXT_LEN = 3;
    localparam t_char DEF_EXT [DEF_EXT_LEN] = '{8'h43, 8'h4F, 8'h4D};

endpackage

// File: rtl/core/sfc_pack.sv
// ----------------------------------------------------------------------------
// sfc_pack
// Input register and per-character packing state; builds the padded name.
// ----------------------------------------------------------------------------
module sfc_pack #(
    parameter int BASE_LEN  = 8,
    parameter int EXT_LEN   = 3,
    parameter int MAX_CHARS = 63,
    parameter int TOTAL     = BASE_LEN + EXT_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  sfc_pkg::t_char                 i_name_char,
    input  logic                           i_end_of_name,
    input  logic                           i_load_ok,
    output logic                           o_load,
    output sfc_pkg::t_char [TOTAL-1:0]     o_snap
);
    import sfc_pkg::*;

    localparam int TAKEN_W = $clog2(MAX_CHARS + 1);
    localparam int BL_W    = $clog2(BASE_LEN + 1);
    localparam int EL_W    = $clog2(EXT_LEN + 1);

    logic               r_in_valid;
    t_char              r_in_char;
    logic               r_in_last;

    t_char [TOTAL-1:0]  r_buf, n_buf;
    logic [BL_W-1:0]    r_base_len, n_base_len;
    logic [EL_W-1:0]    r_ext_len, n_ext_len;
    logic               r_dot, n_dot;
    logic [TAKEN_W-1:0] r_taken, n_taken;
    logic [TOTAL-1:0]   r_blank, n_blank;

    logic advance;
    logic in_free;
    t_char cu;
    logic is_blank;

    assign advance = r_in_valid && (!r_in_last || i_load_ok);
    assign in_free = !r_in_valid || advance;
    assign o_stall = !in_free;
    assign o_load  = advance && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && in_free) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && in_free) begin
            r_in_char <= i_name_char;
            r_in_last <= i_end_of_name;
        end
    end

    always_comb begin
        cu = r_in_char;
        if (r_in_char >= CH_LA && r_in_char <= CH_LZ) begin
            cu = r_in_char - CASE_OFS;
        end
        is_blank = (cu == CH_SPACE) || (cu == CH_TAB);

        n_buf      = r_buf;
        n_base_len = r_base_len;
        n_ext_len  = r_ext_len;
        n_dot      = r_dot;
        n_taken    = r_taken;
        n_blank    = r_blank;

        if (r_taken < TAKEN_W'(MAX_CHARS)) begin
            n_taken = r_taken + 1'b1;
            if (!is_blank) begin
                n_blank = '0;
            end
            if (!r_dot && cu == CH_DOT) begin
                n_dot = 1'b1;
            end else if (!r_dot) begin
                if (r_base_len < BL_W'(BASE_LEN)) begin
                    for (int i = 0; i < BASE_LEN; i++) begin
                        if (r_base_len == BL_W'(i)) begin
                            n_buf[i] = cu;
                            if (is_blank) begin
                                n_blank[i] = 1'b1;
                            end
                        end
                    end
                    n_base_len = r_base_len + 1'b1;
                end
            end else begin
                if (r_ext_len < EL_W'(EXT_LEN)) begin
                    for (int i = 0; i < EXT_LEN; i++) begin
                        if (r_ext_len == EL_W'(i)) begin
                            n_buf[BASE_LEN+i] = cu;
                            if (is_blank) begin
                                n_blank[BASE_LEN+i] = 1'b1;
                            end
                        end
                    end
                    n_ext_len = r_ext_len + 1'b1;
                end
            end
        end
    end

    // Final bytes: pending blanks become spaces, and a name without a dot
    // gets the default extension.
    always_comb begin
        for (int i = 0; i < TOTAL; i++) begin
            o_snap[i] = n_blank[i] ? CH_SPACE : n_buf[i];
            if (!n_dot && i >= BASE_LEN) begin
                if (i - BASE_LEN < DEF_EXT_LEN) begin
                    o_snap[i] = DEF_EXT[2'(i - BASE_LEN)];
                end else begin
                    o_snap[i] = CH_SPACE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_buf      <= {TOTAL{CH_SPACE}};
            r_base_len <= '0;
            r_ext_len  <= '0;
            r_dot      <= 1'b0;
            r_taken    <= '0;
            r_blank    <= '0;
        end else if (advance) begin
            r_buf      <= n_buf;
            r_base_len <= n_base_len;
            r_ext_len  <= n_ext_len;
            r_dot      <= n_dot;
            r_taken    <= n_taken;
            r_blank    <= n_blank;
        end
    end

endmodule

// File: rtl/core/sfc_emit.sv
// ----------------------------------------------------------------------------
// sfc_emit
// Output shift register that sends a packed name one byte per transfer.
// ----------------------------------------------------------------------------
module sfc_emit #(
    parameter int TOTAL = 11
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  sfc_pkg::t_char [TOTAL-1:0]             i_snap,
    output logic                                   o_load_ok,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output sfc_pkg::t_char                         o_packed_char,
    output logic [sfc_pkg::POS_W-1:0]              o_packed_position,
    output logic                                   o_last_of_name
);
    import sfc_pkg::*;

    localparam int CNT_W = $clog2(TOTAL);

    logic              r_busy;
    logic              r_last;
    logic [CNT_W-1:0]  r_pos;
    t_char [TOTAL-1:0] r_sh;

    logic                   out_xfer;
    logic [CNT_W+POS_W-1:0] pos_ext;

    assign out_xfer  = r_busy && !i_stall;
    assign o_load_ok = !r_busy || (out_xfer && r_last);

    assign pos_ext           = {{POS_W{1'b0}}, r_pos};
    assign o_valid           = r_busy;
    assign o_packed_char     = r_sh[0];
    assign o_packed_position = pos_ext[POS_W-1:0];
    assign o_last_of_name    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_last <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_last <= (TOTAL == 1);
        end else if (out_xfer) begin
            if (r_last) begin
                r_busy <= 1'b0;
                r_last <= 1'b0;
            end else begin
                r_last <= (r_pos == CNT_W'(TOTAL - 2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sh  <= i_snap;
            r_pos <= '0;
        end else if (out_xfer && !r_last) begin
            r_sh  <= {CH_SPACE, r_sh[TOTAL-1:1]};
            r_pos <= r_pos + 1'b1;
        end
    end

endmodule

// File: rtl/core/short_filename_converter_top.sv
// ----------------------------------------------------------------------------
// short_filename_converter_top
// Packs a streamed filename into a space-padded 8.3 short name.
// ----------------------------------------------------------------------------
// The input channel carries one filename character per transfer, with
// i_end_of_name marking the final character. The output channel carries the
// packed name as BASE_LEN + EXT_LEN byte transfers (eleven by default), each
// with its byte position, the final one flagged by o_last_of_name.
// Characters enter an input register and are then folded into the packing
// state; one character is taken every cycle unless a final character waits.
// On the final character the finished name is copied into the output shift
// register and the packing state clears at once, ready for the next name.
// From the input register the final character's finished name is loaded into
// the output shift register, which then presents the first byte and sends
// one byte per cycle while the receiver does not stall.
// While a name's bytes drain, the next name's characters are still taken,
// and only its final character waits until the last byte of the previous
// name moves.
// A receiver stall holds the current byte steady and can back up into
// o_stall on the input side. A synchronous reset empties the input register
// and the output register and returns the packing state to all spaces.
module short_filename_converter_top #(
    parameter int BASE_LEN  = 8,
    parameter int EXT_LEN   = 3,
    parameter int MAX_CHARS = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_name_char,
    input  logic                      i_end_of_name,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_packed_char,
    output logic [sfc_pkg::POS_W-1:0] o_packed_position,
    output logic                      o_last_of_name
);
    import sfc_pkg::*;

    localparam int TOTAL = BASE_LEN + EXT_LEN;

    // Hand-over between the packing stage and the output shift register.
    logic              load_ok;
    logic              load;
    t_char [TOTAL-1:0] snap;

    sfc_pack #(
        .BASE_LEN  (BASE_LEN),
        .EXT_LEN   (EXT_LEN),
        .MAX_CHARS (MAX_CHARS),
        .TOTAL     (TOTAL)
    ) u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_name_char   (i_name_char),
        .i_end_of_name (i_end_of_name),
        .i_load_ok     (load_ok),
        .o_load        (load),
        .o_snap        (snap)
    );

    sfc_emit #(
        .TOTAL (TOTAL)
    ) u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load),
        .i_snap            (snap),
        .o_load_ok         (load_ok),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_packed_char     (o_packed_char),
        .o_packed_position (o_packed_position),
        .o_last_of_name    (o_last_of_name)
    );

endmodule

// File: rtl/core/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level assertions for the short filename converter, bound to the top.
// ----------------------------------------------------------------------------
module sfc_checker #(
    parameter int BASE_LEN = 8,
    parameter int EXT_LEN  = 3
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_packed_char,
    input logic [3:0] o_packed_position,
    input logic       o_last_of_name
);
    localparam int TOTAL = BASE_LEN + EXT_LEN;
    localparam logic [3:0] LAST_POS = 4'((TOTAL - 1) % 16);

    // The last byte of a name always sits at the final position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_name) |-> (o_packed_position == LAST_POS))
        else $error("last byte at wrong position");

    // Within a name the bytes follow each other without a gap.
    a_next_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_name) |=>
        (o_valid && o_packed_position == 4'($past(o_packed_position) + 4'd1)))
        else $error("byte sequence broken");

    // A stalled byte holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_packed_char) && $stable(o_packed_position)
         && $stable(o_last_of_name)))
        else $error("stalled byte changed");

    // Reset leaves the output empty.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind short_filename_converter_top sfc_checker #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
) u_sfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_packed_char     (o_packed_char),
    .o_packed_position (o_packed_position),
    .o_last_of_name    (o_last_of_name)
);
